/* hw/rtl/arm_dynamics_euler_step_core_defines.svh */
// assertion macros for the arm dynamics euler step core
// expects clk and rst_n in the scope where a macro is used
`ifndef ARM_DYNAMICS_EULER_STEP_CORE_DEFINES_SVH
`define ARM_DYNAMICS_EULER_STEP_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ADES_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ADES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ades_pkg.sv */
// shared types, constants and helper functions of the arm dynamics euler step core
// no dependencies
`timescale 1ns / 1ps

package ades_pkg;

    localparam int FRAC_BITS  = 24;
    localparam int FMW        = 64 - FRAC_BITS;
    localparam int NA_W       = FMW + 1;
    localparam int NR_W       = FMW + 2;
    localparam int SAT_W      = FMW + 4;
    localparam int GS_W       = 34;
    localparam int PIPE_DEPTH = 26;

    localparam logic [29:0] TURN_SCALE  = 30'd683565276;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [30:0] ONE_Q30     = 31'h40000000;

    localparam int SIN_STEPS = 5;
    localparam int COS_STEPS = 6;

    localparam logic [7:0] SIN_K [SIN_STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [31:0] SIN_R [SIN_STEPS] = '{
        32'd39045157, 32'd59652323, 32'd102261126, 32'd214748364, 32'd715827882
    };
    localparam logic [7:0] COS_K [COS_STEPS] = '{
        8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2
    };
    localparam logic [31:0] COS_R [COS_STEPS] = '{
        32'd32537631, 32'd47721858, 32'd76695844, 32'd143165576, 32'd357913941,
        32'd2147483648
    };

    typedef enum logic [2:0] {
        REG_ANGLE_RATE_GAIN     = 3'd0,
        REG_RATE_ANGLE_GAIN     = 3'd1,
        REG_RATE_DAMPING_GAIN   = 3'd2,
        REG_RATE_PRESSURE_GAIN  = 3'd3,
        REG_PRESSURE_DECAY_GAIN = 3'd4,
        REG_COMMAND_GAIN        = 3'd5,
        REG_GRAVITY_GAIN        = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic signed [31:0] angle_rate_gain;
        logic signed [31:0] rate_angle_gain;
        logic signed [31:0] rate_damping_gain;
        logic signed [31:0] rate_pressure_gain;
        logic signed [31:0] pressure_decay_gain;
        logic signed [31:0] command_gain;
        logic signed [31:0] gravity_gain;
    } gains_t;

    typedef struct packed {
        logic        overflow;
        logic [31:0] curvature_rate_angle;
        logic [31:0] jacobian_rate_angle;
        logic [31:0] next_pressure;
        logic [31:0] next_rate;
        logic [31:0] next_angle;
    } res_t;

    typedef struct packed {
        logic [31:0] val;
        logic        ov;
    } sat_t;

    // q8.24 reset constants scaled to the fraction width in use
    function automatic logic [31:0] scale_reset(input longint v);
        longint w;
        if (FRAC_BITS < 24)
        begin
            w = v + (64'sd1 <<< (23 - FRAC_BITS));
            w = w >>> (24 - FRAC_BITS);
        end
        else
        begin
            w = v <<< (FRAC_BITS - 24);
        end
        return w[31:0];
    endfunction

    localparam logic [31:0] RST_ANGLE_RATE_GAIN     = scale_reset(167772);
    localparam logic [31:0] RST_RATE_ANGLE_GAIN     = scale_reset(-11557992);
    localparam logic [31:0] RST_RATE_DAMPING_GAIN   = scale_reset(16759011);
    localparam logic [31:0] RST_RATE_PRESSURE_GAIN  = scale_reset(7934973);
    localparam logic [31:0] RST_PRESSURE_DECAY_GAIN = scale_reset(17895697);
    localparam logic [31:0] RST_COMMAND_GAIN        = scale_reset(1118481);
    localparam logic [31:0] RST_GRAVITY_GAIN        = scale_reset(7714837);

    // round half up from FRAC_BITS fraction bits
    function automatic logic signed [FMW-1:0] rnd_frac(input logic signed [63:0] p);
        logic signed [63:0] w;
        w = p + (64'sd1 <<< (FRAC_BITS - 1));
        return w[63:FRAC_BITS];
    endfunction

    function automatic sat_t sat32(input logic signed [SAT_W-1:0] v);
        sat_t r;
        r.ov = !((&v[SAT_W-1:31]) || !(|v[SAT_W-1:31]));
        if (r.ov)
        begin
            r.val = v[SAT_W-1] ? 32'h80000000 : 32'h7fffffff;
        end
        else
        begin
            r.val = v[31:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/arm_dynamics_euler_step_core.sv */
// top level of the arm dynamics euler step core: config registers, valid pipeline,
// output register with skid; depends on ades_pkg, ades_trig, ades_linear, ades_combine
//
// usage:
//   configuration: cfg_we with cfg_index (0..6) and cfg_data writes one gain
//   register at the clock edge; indexes outside the list are ignored. write
//   only while no transaction is in flight.
//   input stream s_*: one state and command per transaction, accepted on
//   s_tvalid and s_tready.
//   output stream m_*: one result per input transaction, in order.
//   pipeline: 26 pipeline stages, the first loaded at the accepting edge, then
//   the output register; the series chain of the cosine, six steps of three
//   stages, makes up most of the stages.
//   throughput: one transaction per cycle while s_tready is high.
//   stall: when m_tready is low the result waits in the output register; the
//   next result goes into a skid register and only then does s_tready drop,
//   freezing the whole pipeline until the skid register drains.
//   reset: rst_n clears all valid bits and loads the default gains.
`timescale 1ns / 1ps
`include "arm_dynamics_euler_step_core_defines.svh"

module arm_dynamics_euler_step_core
    import ades_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // angle, rate, pressure, command
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // next_angle, next_rate, next_pressure, jacobian_rate_angle,
    // curvature_rate_angle, overflow, zero fill
    output logic [167:0] m_tdata
);

    gains_t gains_reg;
    logic   v_reg [1:PIPE_DEPTH];
    logic   out_valid_reg;
    logic   skid_valid_reg;
    res_t   out_data_reg;
    res_t   skid_data_reg;

    logic signed [NA_W-1:0] na_dly_reg [4:PIPE_DEPTH-1];
    logic signed [NR_W-1:0] nr_dly_reg [4:PIPE_DEPTH-1];
    logic signed [NA_W-1:0] np_dly_reg [4:PIPE_DEPTH-1];

    logic                   en;
    logic                   out_take;
    logic                   out_saturated;
    logic signed [31:0]     sin_val;
    logic signed [31:0]     cos_val;
    logic signed [NA_W-1:0] na_sum;
    logic signed [NR_W-1:0] nr_sum;
    logic signed [NA_W-1:0] np_sum;
    res_t                   pipe_res;

    assign en       = !skid_valid_reg;
    assign out_take = out_valid_reg && m_tready;
    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.angle_rate_gain     <= RST_ANGLE_RATE_GAIN;
            gains_reg.rate_angle_gain     <= RST_RATE_ANGLE_GAIN;
            gains_reg.rate_damping_gain   <= RST_RATE_DAMPING_GAIN;
            gains_reg.rate_pressure_gain  <= RST_RATE_PRESSURE_GAIN;
            gains_reg.pressure_decay_gain <= RST_PRESSURE_DECAY_GAIN;
            gains_reg.command_gain        <= RST_COMMAND_GAIN;
            gains_reg.gravity_gain        <= RST_GRAVITY_GAIN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ANGLE_RATE_GAIN:     gains_reg.angle_rate_gain     <= cfg_data;
                REG_RATE_ANGLE_GAIN:     gains_reg.rate_angle_gain     <= cfg_data;
                REG_RATE_DAMPING_GAIN:   gains_reg.rate_damping_gain   <= cfg_data;
                REG_RATE_PRESSURE_GAIN:  gains_reg.rate_pressure_gain  <= cfg_data;
                REG_PRESSURE_DECAY_GAIN: gains_reg.pressure_decay_gain <= cfg_data;
                REG_COMMAND_GAIN:        gains_reg.command_gain        <= cfg_data;
                REG_GRAVITY_GAIN:        gains_reg.gravity_gain        <= cfg_data;
                default:                 ;
            endcase
        end
    end

    ades_trig u_trig (
        .clk     (clk),
        .en      (en),
        .angle   (s_tdata[31:0]),
        .sin_val (sin_val),
        .cos_val (cos_val)
    );

    ades_linear u_linear (
        .clk      (clk),
        .en       (en),
        .gains    (gains_reg),
        .angle    (s_tdata[31:0]),
        .rate     (s_tdata[63:32]),
        .pressure (s_tdata[95:64]),
        .command  (s_tdata[127:96]),
        .na_sum   (na_sum),
        .nr_sum   (nr_sum),
        .np_sum   (np_sum)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            na_dly_reg[4] <= na_sum;
            nr_dly_reg[4] <= nr_sum;
            np_dly_reg[4] <= np_sum;
            for (int i = 5; i < PIPE_DEPTH; i++)
            begin
                na_dly_reg[i] <= na_dly_reg[i-1];
                nr_dly_reg[i] <= nr_dly_reg[i-1];
                np_dly_reg[i] <= np_dly_reg[i-1];
            end
        end
    end

    ades_combine u_combine (
        .clk     (clk),
        .en      (en),
        .gains   (gains_reg),
        .sin_val (sin_val),
        .cos_val (cos_val),
        .na_sum  (na_dly_reg[PIPE_DEPTH-1]),
        .nr_sum  (nr_dly_reg[PIPE_DEPTH-1]),
        .np_sum  (np_dly_reg[PIPE_DEPTH-1]),
        .res     (pipe_res)
    );

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= PIPE_DEPTH; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[1] <= s_tvalid;
            for (int i = 2; i <= PIPE_DEPTH; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // output register and skid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (skid_valid_reg)
            begin
                if (out_take)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (v_reg[PIPE_DEPTH])
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (v_reg[PIPE_DEPTH])
        begin
            if (!out_valid_reg || out_take)
            begin
                out_data_reg <= pipe_res;
            end
            else
            begin
                skid_data_reg <= pipe_res;
            end
        end
    end

    // some result field sits at a saturation limit
    assign out_saturated = (out_data_reg.next_angle == 32'h7fffffff)
                        || (out_data_reg.next_angle == 32'h80000000)
                        || (out_data_reg.next_rate == 32'h7fffffff)
                        || (out_data_reg.next_rate == 32'h80000000)
                        || (out_data_reg.next_pressure == 32'h7fffffff)
                        || (out_data_reg.next_pressure == 32'h80000000)
                        || (out_data_reg.jacobian_rate_angle == 32'h7fffffff)
                        || (out_data_reg.jacobian_rate_angle == 32'h80000000)
                        || (out_data_reg.curvature_rate_angle == 32'h7fffffff)
                        || (out_data_reg.curvature_rate_angle == 32'h80000000);

    `ADES_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid without output")
    `ADES_ASSERT_NEXT(a_skid_holds, skid_valid_reg && !m_tready, skid_valid_reg, "skid lost")
    `ADES_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, v_reg[1], "item dropped")
    `ADES_ASSERT_NOW(a_overflow_saturates, out_valid_reg && out_data_reg.overflow, out_saturated, "bad ov")

endmodule

/* hw/rtl/ades_series_step.sv */
// one three-stage step of the sin/cos series: multiply, reciprocal divide, correct
// depends on ades_pkg
`timescale 1ns / 1ps

module ades_series_step
    import ades_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [29:0] x2_in,
    input  logic [30:0] t_in,
    input  logic [7:0]  k,
    input  logic [31:0] recip,
    output logic [29:0] x2_out,
    output logic [30:0] t_out
);

    logic [60:0] mprod_reg;
    logic [29:0] x2_a_reg;
    logic [29:0] x2_b_reg;
    logic [29:0] x2_c_reg;
    logic [29:0] m_b_reg;
    logic [29:0] q0_b_reg;
    logic [30:0] t_c_reg;

    logic [61:0] qprod;
    logic [37:0] qk;
    logic [37:0] rem;
    logic [29:0] q;

    always_comb
    begin
        qprod = {32'b0, mprod_reg[59:30]} * {30'b0, recip};
        qk    = {8'b0, q0_b_reg} * {30'b0, k};
        rem   = {8'b0, m_b_reg} - qk;
        // reciprocal estimate is at most one low
        q     = (rem >= {30'b0, k}) ? q0_b_reg + 30'd1 : q0_b_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mprod_reg <= {31'b0, x2_in} * {30'b0, t_in};
            x2_a_reg  <= x2_in;
            m_b_reg   <= mprod_reg[59:30];
            q0_b_reg  <= qprod[61:32];
            x2_b_reg  <= x2_a_reg;
            t_c_reg   <= ONE_Q30 - {1'b0, q};
            x2_c_reg  <= x2_b_reg;
        end
    end

    assign x2_out = x2_c_reg;
    assign t_out  = t_c_reg;

endmodule

/* hw/rtl/ades_trig.sv */
// sin and cos pipeline: turn reduction, octant fold, series chains, quadrant fixup
// depends on ades_pkg and ades_series_step
`timescale 1ns / 1ps

module ades_trig
    import ades_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] angle,
    output logic signed [31:0] sin_val,
    output logic signed [31:0] cos_val
);

    logic signed [62:0] phase_prod_reg;
    logic [29:0]        u_reg;
    logic [60:0]        xprod_reg;
    logic [59:0]        x2prod_reg;
    logic [1:0]         quad_reg [2:22];
    logic               swap_reg [2:22];
    logic [29:0]        x_dly_reg [4:19];
    logic [60:0]        sprod_reg;
    logic [29:0]        sin_dly_reg [21:22];
    logic signed [31:0] sin_reg;
    logic signed [31:0] cos_reg;

    logic [31:0] phase;
    logic [29:0] r;
    logic [29:0] x;

    logic [29:0] sin_x2 [0:SIN_STEPS];
    logic [30:0] sin_t  [0:SIN_STEPS];
    logic [29:0] cos_x2 [0:COS_STEPS];
    logic [30:0] cos_t  [0:COS_STEPS];

    logic signed [31:0] s0;
    logic signed [31:0] c0;

    always_comb
    begin
        phase = phase_prod_reg[FRAC_BITS+31:FRAC_BITS];
        r     = phase[29:0];
        x     = xprod_reg[59:30];
    end

    assign sin_x2[0] = x2prod_reg[59:30];
    assign sin_t[0]  = ONE_Q30;
    assign cos_x2[0] = x2prod_reg[59:30];
    assign cos_t[0]  = ONE_Q30;

    for (genvar j = 0; j < SIN_STEPS; j++)
    begin : g_sin
        ades_series_step u_step (
            .clk    (clk),
            .en     (en),
            .x2_in  (sin_x2[j]),
            .t_in   (sin_t[j]),
            .k      (SIN_K[j]),
            .recip  (SIN_R[j]),
            .x2_out (sin_x2[j+1]),
            .t_out  (sin_t[j+1])
        );
    end

    for (genvar j = 0; j < COS_STEPS; j++)
    begin : g_cos
        ades_series_step u_step (
            .clk    (clk),
            .en     (en),
            .x2_in  (cos_x2[j]),
            .t_in   (cos_t[j]),
            .k      (COS_K[j]),
            .recip  (COS_R[j]),
            .x2_out (cos_x2[j+1]),
            .t_out  (cos_t[j+1])
        );
    end

    always_comb
    begin
        if (swap_reg[22])
        begin
            s0 = {1'b0, cos_t[COS_STEPS]};
            c0 = {2'b0, sin_dly_reg[22]};
        end
        else
        begin
            s0 = {2'b0, sin_dly_reg[22]};
            c0 = {1'b0, cos_t[COS_STEPS]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phase_prod_reg <= angle * $signed({1'b0, TURN_SCALE});
            quad_reg[2]    <= phase[31:30];
            swap_reg[2]    <= r[29];
            u_reg          <= r[29] ? 30'(ONE_Q30 - {1'b0, r}) : r;
            for (int i = 3; i <= 22; i++)
            begin
                quad_reg[i] <= quad_reg[i-1];
                swap_reg[i] <= swap_reg[i-1];
            end
            xprod_reg      <= {31'b0, u_reg} * {30'b0, HALF_PI_Q30};
            x2prod_reg     <= {30'b0, x} * {30'b0, x};
            x_dly_reg[4]   <= x;
            for (int i = 5; i <= 19; i++)
            begin
                x_dly_reg[i] <= x_dly_reg[i-1];
            end
            sprod_reg       <= {31'b0, x_dly_reg[19]} * {30'b0, sin_t[SIN_STEPS]};
            sin_dly_reg[21] <= sprod_reg[59:30];
            sin_dly_reg[22] <= sin_dly_reg[21];
            unique case (quad_reg[22])
                2'd0:
                begin
                    sin_reg <= s0;
                    cos_reg <= c0;
                end
                2'd1:
                begin
                    sin_reg <= c0;
                    cos_reg <= -s0;
                end
                2'd2:
                begin
                    sin_reg <= -s0;
                    cos_reg <= -c0;
                end
                default:
                begin
                    sin_reg <= -c0;
                    cos_reg <= s0;
                end
            endcase
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

/* hw/rtl/ades_linear.sv */
// linear terms of the state update: six products, rounding, partial sums
// depends on ades_pkg
`timescale 1ns / 1ps

module ades_linear
    import ades_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  gains_t                gains,
    input  logic signed [31:0]    angle,
    input  logic signed [31:0]    rate,
    input  logic signed [31:0]    pressure,
    input  logic signed [31:0]    command,
    output logic signed [NA_W-1:0] na_sum,
    output logic signed [NR_W-1:0] nr_sum,
    output logic signed [NA_W-1:0] np_sum
);

    logic signed [63:0]     p_ar_reg;
    logic signed [63:0]     p_ra_reg;
    logic signed [63:0]     p_rd_reg;
    logic signed [63:0]     p_rp_reg;
    logic signed [63:0]     p_pd_reg;
    logic signed [63:0]     p_cg_reg;
    logic signed [31:0]     angle_d1_reg;
    logic signed [31:0]     angle_d2_reg;
    logic signed [FMW-1:0]  r_ar_reg;
    logic signed [FMW-1:0]  r_ra_reg;
    logic signed [FMW-1:0]  r_rd_reg;
    logic signed [FMW-1:0]  r_rp_reg;
    logic signed [FMW-1:0]  r_pd_reg;
    logic signed [FMW-1:0]  r_cg_reg;
    logic signed [NA_W-1:0] na_reg;
    logic signed [NR_W-1:0] nr_reg;
    logic signed [NA_W-1:0] np_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_ar_reg     <= gains.angle_rate_gain * rate;
            p_ra_reg     <= gains.rate_angle_gain * angle;
            p_rd_reg     <= gains.rate_damping_gain * rate;
            p_rp_reg     <= gains.rate_pressure_gain * pressure;
            p_pd_reg     <= gains.pressure_decay_gain * pressure;
            p_cg_reg     <= gains.command_gain * command;
            angle_d1_reg <= angle;
            r_ar_reg     <= rnd_frac(p_ar_reg);
            r_ra_reg     <= rnd_frac(p_ra_reg);
            r_rd_reg     <= rnd_frac(p_rd_reg);
            r_rp_reg     <= rnd_frac(p_rp_reg);
            r_pd_reg     <= rnd_frac(p_pd_reg);
            r_cg_reg     <= rnd_frac(p_cg_reg);
            angle_d2_reg <= angle_d1_reg;
            na_reg       <= NA_W'(angle_d2_reg) + NA_W'(r_ar_reg);
            nr_reg       <= NR_W'(r_ra_reg) + NR_W'(r_rd_reg) + NR_W'(r_rp_reg);
            np_reg       <= NA_W'(r_pd_reg) + NA_W'(r_cg_reg);
        end
    end

    assign na_sum = na_reg;
    assign nr_sum = nr_reg;
    assign np_sum = np_reg;

endmodule

/* hw/rtl/ades_combine.sv */
// gravity terms, final sums and saturation of the five results
// depends on ades_pkg
`timescale 1ns / 1ps

module ades_combine
    import ades_pkg::*;
(
    input  logic                   clk,
    input  logic                   en,
    input  gains_t                 gains,
    input  logic signed [31:0]     sin_val,
    input  logic signed [31:0]     cos_val,
    input  logic signed [NA_W-1:0] na_sum,
    input  logic signed [NR_W-1:0] nr_sum,
    input  logic signed [NA_W-1:0] np_sum,
    output res_t                   res
);

    logic signed [63:0]     gs_prod_reg;
    logic signed [63:0]     gc_prod_reg;
    logic signed [GS_W-1:0] gs_reg;
    logic signed [GS_W-1:0] gc_reg;
    res_t                   res_reg;

    logic signed [63:0] gs_w;
    logic signed [63:0] gc_w;
    sat_t               na_s;
    sat_t               nr_s;
    sat_t               np_s;
    sat_t               jac_s;
    sat_t               cur_s;

    always_comb
    begin
        gs_w  = gs_prod_reg + 64'sh20000000;
        gc_w  = gc_prod_reg + 64'sh20000000;
        na_s  = sat32(SAT_W'(na_sum));
        nr_s  = sat32(SAT_W'(nr_sum) - SAT_W'(gs_reg));
        np_s  = sat32(SAT_W'(np_sum));
        jac_s = sat32(SAT_W'(gains.rate_angle_gain) - SAT_W'(gc_reg));
        cur_s = sat32(SAT_W'(gs_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gs_prod_reg                  <= gains.gravity_gain * sin_val;
            gc_prod_reg                  <= gains.gravity_gain * cos_val;
            gs_reg                       <= gs_w[63:30];
            gc_reg                       <= gc_w[63:30];
            res_reg.next_angle           <= na_s.val;
            res_reg.next_rate            <= nr_s.val;
            res_reg.next_pressure        <= np_s.val;
            res_reg.jacobian_rate_angle  <= jac_s.val;
            res_reg.curvature_rate_angle <= cur_s.val;
            res_reg.overflow             <= na_s.ov | nr_s.ov | np_s.ov | jac_s.ov | cur_s.ov;
        end
    end

    assign res = res_reg;

endmodule

/* tb/testbench.sv */
// self-checking testbench for arm_dynamics_euler_step_core: directed table, then random phases
// over several gain settings, checked against a fixed-point euler step predictor
// or, for the typed rows, a fixed result; depends on ades_pkg and the core rtl
`timescale 1ns / 1ps

module testbench;
    import ades_pkg::*;

    localparam logic [2:0] REG_UNMAPPED = 3'd7;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS = 170;

    typedef struct {
        logic [31:0] angle;
        logic [31:0] rate;
        logic [31:0] pressure;
        logic [31:0] command;
        bit          typed;
        res_t        result;
    } step_row_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [167:0] m_tdata;

    gains_t gains;
    res_t   expected_steps [$];
    int     error_count;
    int     checked_count;
    int     overflow_count;
    int     burst_left;

    arm_dynamics_euler_step_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #3ms;
        $display("timeout at %0t", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic longint round_shift(input longint v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint qmul(input logic [31:0] a, input logic [31:0] b);
        return round_shift(longint'($signed(a)) * longint'($signed(b)), FRAC_BITS);
    endfunction

    function automatic logic [31:0] clamp32(input longint v, inout logic ov);
        if (v > 64'sd2147483647)
        begin
            ov = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            ov = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    // polynomial sin and cos on the turn fraction of the angle, signed q1.30
    function automatic void turn_sincos(input logic [31:0] ang, output longint s,
                                        output longint c);
        longint unsigned sk [5] = '{110, 72, 42, 20, 6};
        longint unsigned ck [6] = '{132, 90, 56, 30, 12, 2};
        longint          prod;
        logic [31:0]     ph;
        longint unsigned r, u, x, x2, t, so, co;
        longint          s0, c0;
        prod = longint'($signed(ang)) * 64'sd683565276;
        ph = prod[FRAC_BITS+31:FRAC_BITS];
        r = ph[29:0];
        u = (r < (64'd1 << 29)) ? r : (64'd1 << 30) - r;
        x = (u * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        t = 64'd1 << 30;
        for (int i = 0; i < 5; i++)
            t = (64'd1 << 30) - ((x2 * t) >> 30) / sk[i];
        so = (x * t) >> 30;
        t = 64'd1 << 30;
        for (int i = 0; i < 6; i++)
            t = (64'd1 << 30) - ((x2 * t) >> 30) / ck[i];
        co = t;
        s0 = so;
        c0 = co;
        if (r >= (64'd1 << 29))
        begin
            s0 = co;
            c0 = so;
        end
        case (ph[31:30])
            2'd0:
            begin
                s = s0;
                c = c0;
            end
            2'd1:
            begin
                s = c0;
                c = -s0;
            end
            2'd2:
            begin
                s = -s0;
                c = -c0;
            end
            default:
            begin
                s = -c0;
                c = s0;
            end
        endcase
    endfunction

    function automatic res_t euler_step(input logic [31:0] ang, input logic [31:0] rate,
                                        input logic [31:0] pres, input logic [31:0] cmd);
        res_t   res;
        logic   ov;
        longint s, c, gs, gc;
        ov = 1'b0;
        turn_sincos(ang, s, c);
        gs = round_shift(longint'(gains.gravity_gain) * s, 30);
        gc = round_shift(longint'(gains.gravity_gain) * c, 30);
        res.next_angle = clamp32(longint'($signed(ang)) + qmul(gains.angle_rate_gain, rate),
                                 ov);
        res.next_rate = clamp32(qmul(gains.rate_angle_gain, ang)
                                + qmul(gains.rate_damping_gain, rate)
                                + qmul(gains.rate_pressure_gain, pres) - gs, ov);
        res.next_pressure = clamp32(qmul(gains.pressure_decay_gain, pres)
                                    + qmul(gains.command_gain, cmd), ov);
        res.jacobian_rate_angle = clamp32(longint'(gains.rate_angle_gain) - gc, ov);
        res.curvature_rate_angle = clamp32(gs, ov);
        res.overflow = ov;
        return res;
    endfunction

    task automatic write_gain(input logic [2:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_ANGLE_RATE_GAIN:     gains.angle_rate_gain = val;
            REG_RATE_ANGLE_GAIN:     gains.rate_angle_gain = val;
            REG_RATE_DAMPING_GAIN:   gains.rate_damping_gain = val;
            REG_RATE_PRESSURE_GAIN:  gains.rate_pressure_gain = val;
            REG_PRESSURE_DECAY_GAIN: gains.pressure_decay_gain = val;
            REG_COMMAND_GAIN:        gains.command_gain = val;
            REG_GRAVITY_GAIN:        gains.gravity_gain = val;
            default: ;
        endcase
    endtask

    task automatic write_all_gains(input logic [31:0] v [7]);
        write_gain(REG_ANGLE_RATE_GAIN, v[0]);
        write_gain(REG_RATE_ANGLE_GAIN, v[1]);
        write_gain(REG_RATE_DAMPING_GAIN, v[2]);
        write_gain(REG_RATE_PRESSURE_GAIN, v[3]);
        write_gain(REG_PRESSURE_DECAY_GAIN, v[4]);
        write_gain(REG_COMMAND_GAIN, v[5]);
        write_gain(REG_GRAVITY_GAIN, v[6]);
        write_gain(REG_UNMAPPED, $urandom);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_state(input logic [31:0] ang, input logic [31:0] rate,
                              input logic [31:0] pres, input logic [31:0] cmd,
                              input bit typed, input res_t typed_result);
        s_tdata <= {cmd, pres, rate, ang};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        expected_steps.push_back(typed ? typed_result : euler_step(ang, rate, pres, cmd));
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (expected_steps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return $urandom_range(0, 1) ? $urandom_range(0, 32'h07ffffff)
                                           : -$urandom_range(0, 32'h07ffffff);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_angle();
        case ($urandom_range(0, 3))
            0: return $urandom;
            default: return $urandom_range(0, 1) ? $urandom_range(0, 32'h0c000000)
                                                 : -$urandom_range(0, 32'h0c000000);
        endcase
    endfunction

    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = res_t'(m_tdata[160:0]);
            if (expected_steps.size() == 0)
            begin
                $display("%0t unexpected result transaction %h", $time, got);
                error_count++;
            end
            else
            begin
                want = expected_steps.pop_front();
                checked_count++;
                if (got.overflow)
                    overflow_count++;
                if (got.next_angle !== want.next_angle)
                begin
                    $display("%0t next_angle exp %h got %h", $time,
                             want.next_angle, got.next_angle);
                    error_count++;
                end
                if (got.next_rate !== want.next_rate)
                begin
                    $display("%0t next_rate exp %h got %h", $time,
                             want.next_rate, got.next_rate);
                    error_count++;
                end
                if (got.next_pressure !== want.next_pressure)
                begin
                    $display("%0t next_pressure exp %h got %h", $time,
                             want.next_pressure, got.next_pressure);
                    error_count++;
                end
                if (got.jacobian_rate_angle !== want.jacobian_rate_angle)
                begin
                    $display("%0t jacobian_rate_angle exp %h got %h", $time,
                             want.jacobian_rate_angle, got.jacobian_rate_angle);
                    error_count++;
                end
                if (got.curvature_rate_angle !== want.curvature_rate_angle)
                begin
                    $display("%0t curvature_rate_angle exp %h got %h", $time,
                             want.curvature_rate_angle, got.curvature_rate_angle);
                    error_count++;
                end
                if (got.overflow !== want.overflow)
                begin
                    $display("%0t overflow exp %b got %b", $time,
                             want.overflow, got.overflow);
                    error_count++;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off once the run is under way
    initial
    begin
        int  cyc;
        int  hold_left;
        bit  hold_done;
        int  mode;
        cyc = 0;
        hold_left = 0;
        hold_done = 0;
        mode = 0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 64 == 0)
                mode = $urandom_range(0, 3);
            if (!hold_done && checked_count >= 400)
            begin
                hold_done = 1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 9) >= 3);
                    2: m_tready <= cyc[1];
                    default: m_tready <= ($urandom_range(0, 9) >= 7);
                endcase
            end
        end
    end

    initial
    begin
        step_row_t   rows [$];
        step_row_t   row;
        res_t        zero_res;
        logic [31:0] g [7];

        error_count = 0;
        checked_count = 0;
        overflow_count = 0;
        burst_left = 5;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        gains.angle_rate_gain = RST_ANGLE_RATE_GAIN;
        gains.rate_angle_gain = RST_RATE_ANGLE_GAIN;
        gains.rate_damping_gain = RST_RATE_DAMPING_GAIN;
        gains.rate_pressure_gain = RST_RATE_PRESSURE_GAIN;
        gains.pressure_decay_gain = RST_PRESSURE_DECAY_GAIN;
        gains.command_gain = RST_COMMAND_GAIN;
        gains.gravity_gain = RST_GRAVITY_GAIN;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);

        // zero state at reset gains: only the jacobian is nonzero, cos is one
        zero_res = '0;
        zero_res.jacobian_rate_angle = 32'hfed9eb83;
        rows.push_back('{32'h0, 32'h0, 32'h0, 32'h0, 1, zero_res});
        rows.push_back('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, '0});
        rows.push_back('{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0, '0});
        rows.push_back('{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 0, '0});
        rows.push_back('{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, '0});
        rows.push_back('{32'h01921fb5, 32'h01000000, 32'h00800000, 32'hff000000, 0, '0});
        rows.push_back('{32'h03243f6a, 32'hff000000, 32'h02000000, 32'h01000000, 0, '0});
        rows.push_back('{32'hfcdbc096, 32'h00400000, 32'hfe000000, 32'h00000001, 0, '0});
        rows.push_back('{32'h04b65f1f, 32'h0, 32'h0, 32'h0, 0, '0});
        rows.push_back('{32'h06487ed5, 32'h0, 32'h0, 32'h0, 0, '0});
        rows.push_back('{32'h00c90fdb, 32'h00000001, 32'hffffffff, 32'hffffffff, 0, '0});
        rows.push_back('{32'h3243f6a8, 32'h12345678, 32'hedcba987, 32'h55555555, 0, '0});
        rows.push_back('{32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555, 0, '0});
        rows.push_back('{32'h0, 32'h0, 32'h0, 32'h0, 1, zero_res});
        foreach (rows[i])
        begin
            row = rows[i];
            send_state(row.angle, row.rate, row.pressure, row.command, row.typed, row.result);
        end
        drain_pipeline();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: g = '{RST_ANGLE_RATE_GAIN, RST_RATE_ANGLE_GAIN, RST_RATE_DAMPING_GAIN,
                         RST_RATE_PRESSURE_GAIN, RST_PRESSURE_DECAY_GAIN, RST_COMMAND_GAIN,
                         RST_GRAVITY_GAIN};
                1: g = '{7{32'h7fffffff}};
                2: g = '{7{32'h80000000}};
                3: g = '{7{32'h0}};
                default: g = '{$urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom};
            endcase
            write_all_gains(g);
            repeat (PHASE_ITEMS)
                send_state(pick_angle(), pick_word(), pick_word(), pick_word(), 0, '0);
            drain_pipeline();
        end

        $display("checked %0d results over directed rows and 6 gain settings", checked_count);
        $display("%0d results saturated, one long output hold-off applied", overflow_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/ades_pkg.sv
hw/rtl/ades_series_step.sv
hw/rtl/ades_trig.sv
hw/rtl/ades_linear.sv
hw/rtl/ades_combine.sv
hw/rtl/arm_dynamics_euler_step_core.sv
tb/testbench.sv
